// ===== rtl/pow_pkg.sv =====
// shared types, constants and SHA-256 tables for the nonce search block
// no dependencies
package pow_pkg;

  localparam int unsigned NONCE_BITS   = 32;
  localparam int unsigned NONCE_DIGITS = 10;
  localparam int unsigned TS_BITS      = 44;
  localparam int unsigned TS_DIGITS    = 14;
  localparam int unsigned CFG_AW       = 2;
  localparam int unsigned CFG_DW       = 32;

  localparam logic [CFG_AW-1:0] CFG_DIFFICULTY   = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_MAX_ATTEMPTS = 2'd1;

  localparam logic [6:0]  DIFF_RESET  = 7'd4;
  localparam logic [6:0]  DIFF_MAX    = 7'd64;
  localparam logic [7:0]  ASCII_ZERO  = 8'h30;
  localparam logic [7:0]  ASCII_HEXA  = 8'h57;
  localparam logic [7:0]  PAD_BYTE    = 8'h80;
  localparam logic [1:0]  LAST_BLOCK  = 2'd2;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef struct packed {
    logic start;
    logic init;
  } pow_core_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } pow_core_sts_t;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_CONV = 5'b00010,
    ST_HASH = 5'b00100,
    ST_NEXT = 5'b01000,
    ST_OUT  = 5'b10000
  } pow_state_e;

endpackage

// ===== rtl/proof_of_work_nonce_search_top.sv =====
// Nonce search top level: sequencer, job and nonce registers, config and result word.
// A job first converts the timestamp to decimal, then for each nonce tried runs three
// SHA-256 blocks (each the rounds, the chaining add and a sequencer step, all through
// the one round unit); the result word appears once a nonce hits or the attempts run
// out, and is held until taken.
// in_stall_o stays high from accepting a job until its result word is taken.
// depends on pow_pkg, pow_bcd, pow_msg_gen, pow_sha_core
module proof_of_work_nonce_search_top import pow_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_AW-1:0]     cfg_idx_i,
  input  logic [CFG_DW-1:0]     cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [63:0]           prev_hash_w0_i,
  input  logic [63:0]           prev_hash_w1_i,
  input  logic [63:0]           prev_hash_w2_i,
  input  logic [63:0]           prev_hash_w3_i,
  input  logic [63:0]           root_w0_i,
  input  logic [63:0]           root_w1_i,
  input  logic [63:0]           root_w2_i,
  input  logic [63:0]           root_w3_i,
  input  logic [TS_BITS-1:0]    timestamp_ms_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  found_o,
  output logic [31:0]           winning_nonce_o,
  output logic [63:0]           digest_w0_o,
  output logic [63:0]           digest_w1_o,
  output logic [63:0]           digest_w2_o,
  output logic [63:0]           digest_w3_o
);

  pow_state_e                state_q, state_d;
  logic [6:0]                difficulty_q;
  logic [31:0]               max_attempts_q;
  logic [255:0]              prev_q, root_q;
  logic [TS_BITS-1:0]        ts_q;
  logic [3:0]                ts_len_q, ts_len, nonce_len;
  logic [NONCE_BITS-1:0]     nonce_q;
  logic [4*NONCE_DIGITS-1:0] nbcd_q, nbcd_inc;
  logic [31:0]               k_q;
  logic [1:0]                blk_q;
  logic                      found_q;
  logic                      in_acc, out_acc, bcd_done, hit, last_try, more;
  logic [4*TS_DIGITS-1:0]    ts_bcd;
  logic [31:0]               msg_word;
  logic [255:0]              hash;
  logic [3:0]                round;
  logic [32:0]               tries;
  logic [6:0]                need;
  pow_core_ctrl_t            core_ctrl;
  pow_core_sts_t             core_sts;

  assign in_acc  = in_valid_i & ~in_stall_o;
  assign out_acc = out_valid_o & ~out_stall_i;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      difficulty_q   <= DIFF_RESET;
      max_attempts_q <= '1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DIFFICULTY:   difficulty_q   <= cfg_data_i[6:0];
        CFG_MAX_ATTEMPTS: max_attempts_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // timestamp conversion
  pow_bcd u_bcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_acc),
    .value_i (timestamp_ms_i),
    .done_o  (bcd_done),
    .bcd_o   (ts_bcd)
  );

  // message word source
  pow_msg_gen u_msg (
    .prev_i      (prev_q),
    .root_i      (root_q),
    .ts_bcd_i    (ts_bcd),
    .ts_len_i    (ts_len_q),
    .nonce_bcd_i (nbcd_q),
    .nonce_len_i (nonce_len),
    .word_idx_i  ({blk_q, round}),
    .word_o      (msg_word)
  );

  // shared compression unit
  pow_sha_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (core_ctrl),
    .msg_word_i (msg_word),
    .sts_o      (core_sts),
    .round_o    (round),
    .hash_o     (hash)
  );

  // decimal nonce increment and digit count
  always_comb begin
    logic carry;
    carry     = 1'b1;
    nonce_len = 4'd1;
    for (int i = 0; i < NONCE_DIGITS; i++) begin
      if (carry) begin
        if (nbcd_q[4*i +: 4] == 4'd9) begin
          nbcd_inc[4*i +: 4] = 4'd0;
        end else begin
          nbcd_inc[4*i +: 4] = nbcd_q[4*i +: 4] + 4'd1;
          carry = 1'b0;
        end
      end else begin
        nbcd_inc[4*i +: 4] = nbcd_q[4*i +: 4];
      end
      if (nbcd_q[4*i +: 4] != 4'd0) nonce_len = 4'(i + 1);
    end
  end

  // timestamp digit count
  always_comb begin
    ts_len = 4'd1;
    for (int i = 0; i < TS_DIGITS; i++) begin
      if (ts_bcd[4*i +: 4] != 4'd0) ts_len = 4'(i + 1);
    end
  end

  // leading zero digit check and attempt limit
  always_comb begin
    need = (difficulty_q > DIFF_MAX) ? DIFF_MAX : difficulty_q;
    hit  = 1'b1;
    for (int i = 0; i < 64; i++) begin
      if ((7'(i) < need) && (hash[255-4*i -: 4] != 4'd0)) hit = 1'b0;
    end
    tries    = (max_attempts_q == 32'd0) ? 33'd1 : {1'b0, max_attempts_q};
    last_try = ({1'b0, k_q} + 33'd1) >= tries;
    more     = (blk_q != LAST_BLOCK) || (!hit && !last_try);
  end

  // sequencer
  always_comb begin
    state_d        = state_q;
    core_ctrl      = '0;
    case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_CONV;
      ST_CONV: begin
        if (bcd_done) begin
          core_ctrl.start = 1'b1;
          core_ctrl.init  = 1'b1;
          state_d = ST_HASH;
        end
      end
      ST_HASH: if (core_sts.done) state_d = ST_NEXT;
      ST_NEXT: begin
        if (more) begin
          core_ctrl.start = 1'b1;
          core_ctrl.init  = (blk_q == LAST_BLOCK);
          state_d = ST_HASH;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: if (out_acc) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      blk_q    <= '0;
      k_q      <= '0;
      nonce_q  <= '0;
      nbcd_q   <= '0;
      found_q  <= 1'b0;
      ts_len_q <= 4'd1;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        blk_q   <= '0;
        k_q     <= '0;
        nonce_q <= '0;
        nbcd_q  <= '0;
      end
      // timestamp digit count once converted
      if (state_q == ST_CONV && bcd_done) begin
        ts_len_q <= ts_len;
      end
      if (state_q == ST_NEXT) begin
        if (blk_q != LAST_BLOCK) begin
          blk_q <= blk_q + 2'd1;
        end else if (more) begin
          blk_q   <= '0;
          k_q     <= k_q + 32'd1;
          nonce_q <= nonce_q + 1'b1;
          nbcd_q  <= (&nonce_q) ? '0 : nbcd_inc;
        end else begin
          found_q <= hit;
        end
      end
    end
  end

  // job word
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      prev_q <= {prev_hash_w0_i, prev_hash_w1_i, prev_hash_w2_i, prev_hash_w3_i};
      root_q <= {root_w0_i, root_w1_i, root_w2_i, root_w3_i};
      ts_q   <= timestamp_ms_i;
    end
  end

  assign in_stall_o      = (state_q != ST_IDLE);
  assign out_valid_o     = (state_q == ST_OUT);
  assign found_o         = found_q;
  assign winning_nonce_o = nonce_q[31:0];
  assign digest_w0_o     = hash[255:192];
  assign digest_w1_o     = hash[191:128];
  assign digest_w2_o     = hash[127:64];
  assign digest_w3_o     = hash[63:0];

  // checks
  a_out_core_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !core_sts.busy) else $error("result word shown while core busy");
  a_accept_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_CONV)) else $error("job not followed by conversion");
  a_hash_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_HASH) |-> core_sts.busy) else $error("hash state with idle core");
  a_job_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_HASH) |-> $stable(ts_q)) else $error("job changed mid search");

endmodule

// ===== rtl/pow_bcd.sv =====
// binary to packed decimal converter, one shift-and-adjust step a cycle
// depends on pow_pkg
module pow_bcd import pow_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [TS_BITS-1:0]     value_i,
  output logic                   done_o,
  output logic [4*TS_DIGITS-1:0] bcd_o
);

  logic [TS_BITS-1:0]     sh_q;
  logic [4*TS_DIGITS-1:0] bcd_q, adj;
  logic [5:0]             cnt_q;
  logic                   run_q, done_q;

  // add three to every digit of five or more
  always_comb begin
    for (int i = 0; i < TS_DIGITS; i++) begin
      adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3 : bcd_q[4*i +: 4];
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= !start_i && run_q && (cnt_q == 6'(TS_BITS - 1));
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'(TS_BITS - 1)) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  // shift datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sh_q  <= value_i;
      bcd_q <= '0;
    end else if (run_q) begin
      sh_q  <= {sh_q[TS_BITS-2:0], 1'b0};
      bcd_q <= {adj[4*TS_DIGITS-2:0], sh_q[TS_BITS-1]};
    end
  end

  assign done_o = done_q;
  assign bcd_o  = bcd_q;

endmodule

// ===== rtl/pow_msg_gen.sv =====
// builds one 32-bit message word of the padded ascii job message
// depends on pow_pkg
module pow_msg_gen import pow_pkg::*; (
  input  logic [255:0]              prev_i,
  input  logic [255:0]              root_i,
  input  logic [4*TS_DIGITS-1:0]    ts_bcd_i,
  input  logic [3:0]                ts_len_i,
  input  logic [4*NONCE_DIGITS-1:0] nonce_bcd_i,
  input  logic [3:0]                nonce_len_i,
  input  logic [5:0]                word_idx_i,
  output logic [31:0]               word_o
);

  function automatic logic [7:0] hex_ch(logic [3:0] n);
    return (n < 4'd10) ? ASCII_ZERO + {4'd0, n} : ASCII_HEXA + {4'd0, n};
  endfunction

  logic [8:0] ts_end, root_end, msg_len;
  logic [10:0] bit_len;

  assign ts_end   = 9'd64 + {5'd0, ts_len_i};
  assign root_end = ts_end + 9'd64;
  assign msg_len  = root_end + {5'd0, nonce_len_i};
  assign bit_len  = {msg_len[7:0], 3'b000};

  // one character per byte lane
  always_comb begin
    logic [8:0] p, rel;
    logic [5:0] nib;
    logic [3:0] di;
    for (int b = 0; b < 4; b++) begin
      p   = {1'b0, word_idx_i, 2'(b)};
      rel = '0;
      nib = '0;
      di  = '0;
      word_o[31-8*b -: 8] = 8'h00;
      if (p < 9'd64) begin
        nib = p[5:0];
        word_o[31-8*b -: 8] = hex_ch(4'(prev_i >> {~nib, 2'b00}));
      end else if (p < ts_end) begin
        rel = p - 9'd64;
        di  = ts_len_i - 4'd1 - rel[3:0];
        word_o[31-8*b -: 8] = ASCII_ZERO + {4'd0, 4'(ts_bcd_i >> {di, 2'b00})};
      end else if (p < root_end) begin
        rel = p - ts_end;
        nib = rel[5:0];
        word_o[31-8*b -: 8] = hex_ch(4'(root_i >> {~nib, 2'b00}));
      end else if (p < msg_len) begin
        rel = p - root_end;
        di  = nonce_len_i - 4'd1 - rel[3:0];
        word_o[31-8*b -: 8] = ASCII_ZERO + {4'd0, 4'(nonce_bcd_i >> {di, 2'b00})};
      end else if (p == msg_len) begin
        word_o[31-8*b -: 8] = PAD_BYTE;
      end else if (p == 9'd190) begin
        word_o[31-8*b -: 8] = {5'd0, bit_len[10:8]};
      end else if (p == 9'd191) begin
        word_o[31-8*b -: 8] = bit_len[7:0];
      end
    end
  end

endmodule

// ===== rtl/pow_sha_core.sv =====
// SHA-256 compression unit, one round a cycle, chaining state kept inside
// depends on pow_pkg
module pow_sha_core import pow_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  pow_core_ctrl_t ctrl_i,
  input  logic [31:0]    msg_word_i,
  output pow_core_sts_t  sts_o,
  output logic [3:0]     round_o,
  output logic [255:0]   hash_o
);

  logic [31:0] h_q [8];
  logic [31:0] v_q [8];
  logic [31:0] s_q [16];
  logic [5:0]  t_q;
  logic        run_q, add_q;
  logic [31:0] w, s0, s1, ch, mj, t1, t2, ws0, ws1;

  // schedule word and round function
  always_comb begin
    ws0 = {s_q[1][6:0], s_q[1][31:7]} ^ {s_q[1][17:0], s_q[1][31:18]} ^ (s_q[1] >> 3);
    ws1 = {s_q[14][16:0], s_q[14][31:17]} ^ {s_q[14][18:0], s_q[14][31:19]}
        ^ (s_q[14] >> 10);
    w   = (t_q < 6'd16) ? msg_word_i : ws1 + s_q[9] + ws0 + s_q[0];
    s1  = {v_q[4][5:0], v_q[4][31:6]} ^ {v_q[4][10:0], v_q[4][31:11]}
        ^ {v_q[4][24:0], v_q[4][31:25]};
    ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    t1  = v_q[7] + s1 + ch + ROUND_K[t_q] + w;
    s0  = {v_q[0][1:0], v_q[0][31:2]} ^ {v_q[0][12:0], v_q[0][31:13]}
        ^ {v_q[0][21:0], v_q[0][31:22]};
    mj  = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t2  = s0 + mj;
  end

  // sequencing and chaining state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      add_q <= 1'b0;
      t_q   <= '0;
      for (int i = 0; i < 8; i++) h_q[i] <= INIT_H[i];
    end else begin
      if (ctrl_i.start) begin
        run_q <= 1'b1;
        t_q   <= '0;
        if (ctrl_i.init) begin
          for (int i = 0; i < 8; i++) h_q[i] <= INIT_H[i];
        end
      end else if (run_q) begin
        t_q <= t_q + 6'd1;
        if (t_q == 6'd63) begin
          run_q <= 1'b0;
          add_q <= 1'b1;
        end
      end else if (add_q) begin
        add_q <= 1'b0;
        for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
      end
    end
  end

  // working variables and schedule window
  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      for (int i = 0; i < 8; i++) v_q[i] <= ctrl_i.init ? INIT_H[i] : h_q[i];
    end else if (run_q) begin
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
      for (int i = 0; i < 15; i++) s_q[i] <= s_q[i+1];
      s_q[15] <= w;
    end
  end

  assign sts_o.busy = run_q | add_q;
  assign sts_o.done = add_q;
  assign round_o    = t_q[3:0];
  assign hash_o     = {h_q[0], h_q[1], h_q[2], h_q[3], h_q[4], h_q[5], h_q[6], h_q[7]};

endmodule
